### design/bb3_pkg.sv
// Shared types and constants of the 3x3 RGB box blur.
// Used by every module of the block; depends on nothing.
package bb3_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One window column: three vertically adjacent pixels
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  // Which neighbours of the centre pixel fall outside the frame
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  typedef struct packed {
    pix_t pix;
    logic frame_end;
  } out_word_t;

  localparam int WIN_SIZE = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 13;
  localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  // Arithmetic: sum * 1.11111 (Q1.24), then divide by nine via reciprocal
  localparam int SUM_W       = 12;
  localparam int GAIN_W      = 25;
  localparam int GAIN_SHIFT  = 24;
  localparam logic [GAIN_W-1:0] GAIN_Q24 = 25'd18641332;
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 12'd3641;
  localparam int QUO_W       = 9;

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

endpackage

### design/bb3_col_cell.sv
// One cell of the window chain: holds a column of three pixels.
// Depends on bb3_pkg for the column type.
module bb3_col_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  bb3_pkg::column_t d_i,
  output bb3_pkg::column_t q_o
);
  import bb3_pkg::*;

  column_t col_q;

  // Take the neighbour's column on every shift
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= d_i;
    end
  end

  assign q_o = col_q;

endmodule

### design/bb3_line_store.sv
// Upper and middle line stores with registered read and write-to-read bypass.
// Depends on bb3_pkg for the pixel type.
module bb3_line_store #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  bb3_pkg::pix_t            wr_px_i,
  output bb3_pkg::pix_t            up_o,
  output bb3_pkg::pix_t            mid_o
);
  import bb3_pkg::*;

  pix_t mem_upper [DEPTH];
  pix_t mem_middle [DEPTH];

  pix_t rd_up_q;
  pix_t rd_mid_q;
  pix_t byp_up_q;
  pix_t byp_mid_q;
  logic byp_q;

  // Middle row moves up, new pixel becomes the middle row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_upper[wr_addr_i]  <= mid_o;
      mem_middle[wr_addr_i] <= wr_px_i;
    end
    if (rd_en_i) begin
      rd_up_q  <= mem_upper[rd_addr_i];
      rd_mid_q <= mem_middle[rd_addr_i];
    end
  end

  // A read of the column written at the same edge takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_up_q  <= mid_o;
      byp_mid_q <= wr_px_i;
    end
  end

  assign up_o  = byp_q ? byp_up_q  : rd_up_q;
  assign mid_o = byp_q ? byp_mid_q : rd_mid_q;

endmodule

### design/bb3_chan_calc.sv
// Per-channel arithmetic: window sum, gain, divide by nine, saturate.
// Depends on bb3_pkg for the border type and arithmetic constants.
module bb3_chan_calc (
  input  logic                                clk_i,
  input  logic [2:0][2:0][7:0]                win_i,    // [column][row]
  input  bb3_pkg::border_t                    border_i,
  output logic [7:0]                          q_o
);
  import bb3_pkg::*;

  logic [SUM_W-1:0]             sum_d;
  logic [SUM_W-1:0]             sum_q;
  logic [SUM_W+GAIN_W-1:0]      gain_prod;
  logic [SUM_W-1:0]             scaled_q;
  logic [SUM_W+RECIP_W-1:0]     div_prod;
  logic [QUO_W-1:0]             quo;

  // Outside neighbours take the centre value; an outside row counts thrice
  always_comb begin
    logic [7:0] ctr;
    logic [9:0] ctr3;
    logic [7:0] lft;
    logic [7:0] rgt;
    logic [9:0] rsum;
    ctr   = win_i[1][1];
    ctr3  = {2'b00, ctr} + {1'b0, ctr, 1'b0};
    sum_d = '0;
    for (int r = 0; r < WIN_SIZE; r++) begin
      lft  = border_i.left  ? ctr : win_i[0][r];
      rgt  = border_i.right ? ctr : win_i[2][r];
      rsum = {2'b00, lft} + {2'b00, win_i[1][r]} + {2'b00, rgt};
      if ((r == 0 && border_i.top) || (r == WIN_SIZE - 1 && border_i.bottom)) begin
        rsum = ctr3;
      end
      sum_d = sum_d + SUM_W'(rsum);
    end
  end

  assign gain_prod = {{GAIN_W{1'b0}}, sum_q} * {{SUM_W{1'b0}}, GAIN_Q24};

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    scaled_q <= gain_prod[GAIN_SHIFT +: SUM_W];
  end

  // Exact floor division by nine for any 12-bit value
  assign div_prod = {{RECIP_W{1'b0}}, scaled_q} * {{SUM_W{1'b0}}, RECIP_NINE};
  assign quo      = div_prod[RECIP_SHIFT +: QUO_W];
  assign q_o      = quo[QUO_W-1] ? 8'hFF : quo[7:0];

endmodule

### design/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, bb3_line_store, bb3_col_cell and bb3_chan_calc.
//
// Usage:
//   Pixels enter in raster order on the input channel (in_valid_i/in_ready_o);
//   blurred pixels leave on the output channel (out_valid_o/out_ready_i).
//   A word is moved when valid and ready are both high at a rising edge.
//   Each output pixel trails its input by one row plus one pixel; after the
//   last pixel of a frame send image_width+1 flush words to drain the last
//   row. frame_end_o marks the final output pixel of the frame.
//   Throughput is one word per clock while in_ready_o is high. A result word
//   passes the line store read, the window shift, the window sum and the
//   gain multiply registers in that order before the output queue; the
//   divide and saturation sit in front of the output queue.
//   The output queue holds eight words. in_ready_o falls only when eight
//   results are in flight or queued, so a stalled receiver backs up into the
//   queue and then halts intake; no word is lost.
//   Reset sets width 640 and height 480 and starts a new frame. Line stores
//   need no clearing: entries not yet written only feed rows outside the
//   frame. A write to the width or height register also restarts the frame.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        red_in_i,
  input  logic [7:0]                        green_in_i,
  input  logic [7:0]                        blue_in_i,
  input  logic                              flush_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        red_out_o,
  output logic [7:0]                        green_out_o,
  output logic [7:0]                        blue_out_o,
  output logic                              frame_end_o
);
  import bb3_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);        // column index
  localparam int WW   = $clog2(MAX_WIDTH + 1);    // effective width
  localparam int HW   = $clog2(MAX_HEIGHT + 1);   // effective height
  localparam int RW   = $clog2(MAX_HEIGHT + 2);   // row counter, runs to height+1
  localparam int WCMP = (WW > IMAGE_WIDTH_W)  ? WW : IMAGE_WIDTH_W;
  localparam int HCMP = (HW > IMAGE_HEIGHT_W) ? HW : IMAGE_HEIGHT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers and effective frame size
  // ---------------------------------------------------------------------------
  logic [IMAGE_WIDTH_W-1:0]  image_width_q;
  logic [IMAGE_HEIGHT_W-1:0] image_height_q;
  logic                      cfg_hit;
  logic [WCMP-1:0]           w_ext;
  logic [HCMP-1:0]           h_ext;
  logic [WW-1:0]             w_eff;
  logic [HW-1:0]             h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[IMAGE_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[IMAGE_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_i)
      REG_IMAGE_WIDTH:  cfg_hit = cfg_we_i;
      REG_IMAGE_HEIGHT: cfg_hit = cfg_we_i;
      default:          cfg_hit = 1'b0;
    endcase
  end

  // Zero counts as one; a width beyond the line store counts as its depth, a height beyond MAX_HEIGHT as MAX_HEIGHT
  assign w_ext = WCMP'(image_width_q);
  assign h_ext = HCMP'(image_height_q);

  always_comb begin
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_ext);
    end
    if (h_ext == '0) begin
      h_eff = HW'(1);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(h_ext);
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: position counters and per-word decode
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [OCC_W-1:0] occ_q;
  logic          take;
  logic          draining;
  logic          proc;
  logic          emit;
  logic [CW-1:0] x;
  logic [RW-1:0] y;
  border_t       border;
  logic          last;
  logic [WW-1:0] col_inc;
  pix_t          px;

  assign in_ready_o = occ_q < OCC_W'(FIFO_DEPTH);
  assign take       = in_valid_i && in_ready_o;
  assign draining   = row_q >= RW'(h_eff);
  // A flush inside a frame, or with no frame open, is dropped without effect
  assign proc       = take && !(flush_i && !draining);
  assign emit       = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));

  // The word completes the window of the pixel one row up and one column left
  always_comb begin
    if (col_q != '0) begin
      x = col_q - CW'(1);
      y = row_q - RW'(1);
    end else begin
      x = CW'(w_eff - WW'(1));
      y = row_q - RW'(2);
    end
    border.top    = (y == '0);
    border.bottom = (y >= RW'(h_eff - HW'(1)));
    border.left   = (x == '0);
    border.right  = (x >= CW'(w_eff - WW'(1)));
    last          = border.right && border.bottom;
  end

  // While draining the colour data is discarded
  always_comb begin
    if (draining) begin
      px = '0;
    end else begin
      px.red   = red_in_i;
      px.green = green_in_i;
      px.blue  = blue_in_i;
    end
  end

  assign col_inc = WW'(col_q) + WW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (proc) begin
      if (emit && last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read data arrives, window loads
  // ---------------------------------------------------------------------------
  logic          s1_valid_q;
  logic          s1_emit_q;
  border_t       s1_border_q;
  logic          s1_last_q;
  logic [CW-1:0] s1_addr_q;
  pix_t          s1_px_q;
  pix_t          ls_up;
  pix_t          ls_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= proc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      s1_emit_q   <= emit;
      s1_border_q <= border;
      s1_last_q   <= last;
      s1_addr_q   <= col_q;
      s1_px_q     <= px;
    end
  end

  bb3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (proc),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_addr_q),
    .wr_px_i   (s1_px_q),
    .up_o      (ls_up),
    .mid_o     (ls_mid)
  );

  // Window chain: the right cell takes the new column, the others pass left
  column_t cell_d [WIN_SIZE];
  column_t cell_q [WIN_SIZE];

  always_comb begin
    cell_d[WIN_SIZE-1].top = ls_up;
    cell_d[WIN_SIZE-1].mid = ls_mid;
    cell_d[WIN_SIZE-1].bot = s1_px_q;
    for (int i = 0; i < WIN_SIZE - 1; i++) begin
      cell_d[i] = cell_q[i+1];
    end
  end

  for (genvar i = 0; i < WIN_SIZE; i++) begin : g_cell
    bb3_col_cell u_cell (
      .clk_i (clk_i),
      .en_i  (s1_valid_q),
      .d_i   (cell_d[i]),
      .q_o   (cell_q[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Stages 2 to 4: sum, gain, divide; only words that give a result go on
  // ---------------------------------------------------------------------------
  logic    s2_valid_q, s3_valid_q, s4_valid_q;
  border_t s2_border_q;
  logic    s2_last_q, s3_last_q, s4_last_q;
  logic [2:0][2:0][7:0] win_red, win_green, win_blue;
  pix_t    res_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_border_q <= s1_border_q;
    s2_last_q   <= s1_last_q;
    s3_last_q   <= s2_last_q;
    s4_last_q   <= s3_last_q;
  end

  always_comb begin
    for (int c = 0; c < WIN_SIZE; c++) begin
      win_red[c][0]   = cell_q[c].top.red;
      win_red[c][1]   = cell_q[c].mid.red;
      win_red[c][2]   = cell_q[c].bot.red;
      win_green[c][0] = cell_q[c].top.green;
      win_green[c][1] = cell_q[c].mid.green;
      win_green[c][2] = cell_q[c].bot.green;
      win_blue[c][0]  = cell_q[c].top.blue;
      win_blue[c][1]  = cell_q[c].mid.blue;
      win_blue[c][2]  = cell_q[c].bot.blue;
    end
  end

  bb3_chan_calc u_calc_red (
    .clk_i    (clk_i),
    .win_i    (win_red),
    .border_i (s2_border_q),
    .q_o      (res_pix.red)
  );

  bb3_chan_calc u_calc_green (
    .clk_i    (clk_i),
    .win_i    (win_green),
    .border_i (s2_border_q),
    .q_o      (res_pix.green)
  );

  bb3_chan_calc u_calc_blue (
    .clk_i    (clk_i),
    .win_i    (win_blue),
    .border_i (s2_border_q),
    .q_o      (res_pix.blue)
  );

  // ---------------------------------------------------------------------------
  // Output queue; occupancy counts results from intake until they leave
  // ---------------------------------------------------------------------------
  out_word_t        fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [OCC_W-1:0] cnt_q;
  logic             push;
  logic             pop;
  logic             occ_add;
  out_word_t        head;

  assign push    = s4_valid_q;
  assign pop     = out_valid_o && out_ready_i;
  assign occ_add = proc && emit;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{pix: res_pix, frame_end: s4_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      occ_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + OCC_W'(1);
        2'b01:   cnt_q <= cnt_q - OCC_W'(1);
        default: cnt_q <= cnt_q;
      endcase
      case ({occ_add, pop})
        2'b10:   occ_q <= occ_q + OCC_W'(1);
        2'b01:   occ_q <= occ_q - OCC_W'(1);
        default: occ_q <= occ_q;
      endcase
    end
  end

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = cnt_q != '0;
  assign red_out_o   = head.pix.red;
  assign green_out_o = head.pix.green;
  assign blue_out_o  = head.pix.blue;
  assign frame_end_o = head.frame_end;

endmodule
